// File: sv/b64u_pkg.sv
// Shared types, constants and alphabet functions of the base64url stream codec.
package b64u_pkg;

    localparam int unsigned B64U_QDEPTH = 4;
    localparam int unsigned B64U_QPTR_W = $clog2(B64U_QDEPTH);
    localparam int unsigned B64U_QCNT_W = $clog2(B64U_QDEPTH + 1);

    localparam logic B64U_DIR_ENCODE = 1'b0;
    localparam logic B64U_DIR_DECODE = 1'b1;

    // One unit of work for the back end: up to four results.
    typedef struct packed {
        logic [23:0] group;   // encode: 24-bit group; decode: byte in [7:0]
        logic [1:0]  cnt_m1;  // number of results minus one
        logic        enc;     // 1: group holds sextets to map to characters
        logic        last;    // final result of this job closes the stream
        logic        err;     // decode failure result
    } b64u_job_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } b64u_sextet_t;

    function automatic logic [7:0] b64u_char(input logic [5:0] idx);
        logic [7:0] c;
        if (idx < 6'd26)
            c = 8'h41 + {2'b00, idx};
        else if (idx < 6'd52)
            c = 8'h61 + {2'b00, idx} - 8'd26;
        else if (idx < 6'd62)
            c = 8'h30 + {2'b00, idx} - 8'd52;
        else if (idx == 6'd62)
            c = 8'h2D;
        else
            c = 8'h5F;
        return c;
    endfunction

    function automatic b64u_sextet_t b64u_value(input logic [7:0] c);
        b64u_sextet_t s;
        s.valid = 1'b1;
        s.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A)
            s.value = 6'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A)
            s.value = 6'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39)
            s.value = 6'(c - 8'h30 + 8'd52);
        else if (c == 8'h2D)
            s.value = 6'd62;
        else if (c == 8'h5F)
            s.value = 6'd63;
        else
            s.valid = 1'b0;
        return s;
    endfunction

endpackage

// File: sv/b64u_front.sv
// Front end: accepts items, keeps stream state and turns items into jobs.
module b64u_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                in_ready,
    input  logic                q_full,
    output logic                push,
    output b64u_pkg::b64u_job_t job
);
    import b64u_pkg::*;

    logic         direction_reg, direction_next;
    logic [15:0]  held_bytes_reg, held_bytes_next;
    logic [1:0]   held_count_reg, held_count_next;
    logic [5:0]   bit_store_reg, bit_store_next;
    logic [2:0]   bit_count_reg, bit_count_next;
    logic [1:0]   char_phase_reg, char_phase_next;
    logic         discarding_reg, discarding_next;

    logic         accept;
    b64u_sextet_t sx;
    logic [11:0]  acc;
    logic [7:0]   dec_byte;
    logic         emit;
    logic [1:0]   phase_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign sx       = b64u_value(in_byte);
    assign acc      = {bit_store_reg, sx.value};
    assign phase_inc = char_phase_reg + 2'd1;

    // Bits held are 0, 2, 4 or 6; a byte leaves once eight are present.
    always_comb
    begin
        emit           = 1'b1;
        dec_byte       = 8'd0;
        bit_store_next = 6'd0;
        bit_count_next = 3'd0;
        unique case (bit_count_reg)
            3'd2:
            begin
                dec_byte       = acc[7:0];
                bit_count_next = 3'd0;
            end
            3'd4:
            begin
                dec_byte       = acc[9:2];
                bit_store_next = {4'd0, acc[1:0]};
                bit_count_next = 3'd2;
            end
            3'd6:
            begin
                dec_byte       = acc[11:4];
                bit_store_next = {2'd0, acc[3:0]};
                bit_count_next = 3'd4;
            end
            default:
            begin
                emit           = 1'b0;
                bit_store_next = sx.value;
                bit_count_next = 3'd6;
            end
        endcase
    end

    always_comb
    begin
        direction_next  = direction_reg;
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        char_phase_next = char_phase_reg;
        discarding_next = discarding_reg;
        push            = 1'b0;
        job.group       = 24'd0;
        job.cnt_m1      = 2'd0;
        job.enc         = 1'b0;
        job.last        = in_last;
        job.err         = 1'b0;

        if (cfg_we)
        begin
            direction_next  = cfg_wdata;
            held_bytes_next = 16'd0;
            held_count_next = 2'd0;
            char_phase_next = 2'd0;
            discarding_next = 1'b0;
        end
        else if (accept && direction_reg == B64U_DIR_ENCODE)
        begin
            job.enc = 1'b1;
            if (held_count_reg >= 2'd2)
            begin
                push            = 1'b1;
                job.group       = {held_bytes_reg, in_byte};
                job.cnt_m1      = 2'd3;
                held_bytes_next = 16'd0;
                held_count_next = 2'd0;
            end
            else if (!in_last)
            begin
                held_bytes_next = {held_bytes_reg[7:0], in_byte};
                held_count_next = held_count_reg + 2'd1;
            end
            else
            begin
                push = 1'b1;
                if (held_count_reg == 2'd0)
                begin
                    job.group  = {in_byte, 16'd0};
                    job.cnt_m1 = 2'd1;
                end
                else
                begin
                    job.group  = {held_bytes_reg[7:0], in_byte, 8'd0};
                    job.cnt_m1 = 2'd2;
                end
                held_bytes_next = 16'd0;
                held_count_next = 2'd0;
            end
        end
        else if (accept)
        begin
            if (discarding_reg)
            begin
                if (in_last)
                begin
                    discarding_next = 1'b0;
                    char_phase_next = 2'd0;
                end
            end
            else if (!sx.valid)
            begin
                push            = 1'b1;
                job.last        = 1'b1;
                job.err         = 1'b1;
                char_phase_next = 2'd0;
                discarding_next = !in_last;
            end
            else if (in_last)
            begin
                push            = 1'b1;
                job.err         = (phase_inc == 2'd1) || !emit;
                job.group       = {16'd0, job.err ? 8'd0 : dec_byte};
                char_phase_next = 2'd0;
            end
            else
            begin
                push            = emit;
                job.group       = {16'd0, dec_byte};
                char_phase_next = phase_inc;
            end
        end
    end

    logic dec_clear;
    logic dec_keep;
    assign dec_clear = cfg_we ||
                       (accept && direction_reg == B64U_DIR_DECODE &&
                        (in_last || !sx.valid));
    assign dec_keep  = !accept || direction_reg != B64U_DIR_DECODE || discarding_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg  <= B64U_DIR_ENCODE;
            held_bytes_reg <= 16'd0;
            held_count_reg <= 2'd0;
            bit_store_reg  <= 6'd0;
            bit_count_reg  <= 3'd0;
            char_phase_reg <= 2'd0;
            discarding_reg <= 1'b0;
        end
        else
        begin
            direction_reg  <= direction_next;
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
            char_phase_reg <= char_phase_next;
            discarding_reg <= discarding_next;
            // Drop the bit store at stream end, on errors and on config writes.
            if (dec_clear)
            begin
                bit_store_reg <= 6'd0;
                bit_count_reg <= 3'd0;
            end
            else if (!dec_keep)
            begin
                bit_store_reg <= bit_store_next;
                bit_count_reg <= bit_count_next;
            end
        end
    end

endmodule

// File: sv/b64u_fifo.sv
// Short job queue between the front and back ends.
module b64u_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64u_pkg::b64u_job_t push_job,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output b64u_pkg::b64u_job_t head_job
);
    import b64u_pkg::*;

    b64u_job_t              mem_reg [B64U_QDEPTH];
    logic [B64U_QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [B64U_QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [B64U_QCNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign full       = count_reg == B64U_QCNT_W'(B64U_QDEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: sv/b64u_back.sv
// Back end: walks each job into the output register, one result per cycle while the output is not stalled.
module b64u_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  b64u_pkg::b64u_job_t head_job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last,
    output logic [1:0]          out_flags
);
    import b64u_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic [1:0] flags_reg, flags_next;
    logic       load, final_res;
    logic [5:0] sextet;

    assign load      = head_valid && (!valid_reg || out_ready);
    assign final_res = idx_reg == head_job.cnt_m1;
    assign pop       = load && final_res;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sextet = head_job.group[23:18];
            2'd1:    sextet = head_job.group[17:12];
            2'd2:    sextet = head_job.group[11:6];
            default: sextet = head_job.group[5:0];
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        byte_next  = byte_reg;
        last_next  = last_reg;
        flags_next = flags_reg;
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = head_job.enc ? b64u_char(sextet) : head_job.group[7:0];
            last_next  = head_job.last && final_res;
            // flags: error above has_data
            flags_next = {!head_job.enc && head_job.err,
                          head_job.enc || !head_job.err};
            idx_next   = final_res ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        flags_reg <= flags_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_flags = flags_reg;

endmodule

// File: sv/base64url_stream_codec.sv
// Top level of the URL-safe base64 stream codec without padding.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata: in_byte; tlast: in_last
//  m_axis   | out       | tdata: out_byte; tuser: has_data, error; tlast: out_last
//  cfg      | in        | cfg_wdata: direction (0 encode, 1 decode)
//
// An input request is taken whenever the four-entry job queue has room; each
// request yields zero to four results. The back end issues one result per
// cycle while the output is not stalled.
// Reset (rst_n low) empties the queue, clears stream state and selects encode.
// Output stalls fill the queue and then hold s_axis_tready low.
module base64url_stream_codec (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] has_data, [1] error
    output logic       m_axis_tlast
);
    import b64u_pkg::*;

    b64u_job_t push_job;
    b64u_job_t head_job;
    logic      push, q_full, head_valid, pop;

    b64u_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .q_full    (q_full),
        .push      (push),
        .job       (push_job)
    );

    b64u_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b64u_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_flags  (m_axis_tuser)
    );

endmodule
